FILE: sv/text_console_writer_top_defines.svh
// assertion macros for the text console writer
// used by text_console_writer_top; expects clk and rst in scope
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// condition must hold in the same cycle
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the following cycle
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
// shared types and constants for the text console writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int ROW_IN_W  = 6;
  localparam int COL_IN_W  = 7;
  localparam int ROW_OUT_W = 6;
  localparam int COL_OUT_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // request kinds
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BGND = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [CHAR_W-1:0]   char_code;
    logic [ROW_IN_W-1:0] read_row;
    logic [COL_IN_W-1:0] read_col;
  } tcw_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic                 scrolled;
  } tcw_result_t;

  typedef struct packed {
    logic clearing;
    logic scrolling;
  } tcw_status_t;

endpackage

FILE: sv/text_console_writer_top.sv
// Text console writer, top level. Use:
// - request channel (req_valid/req_stall): req_type 0 puts char_code at the
//   cursor (10 is a newline), req_type 1 reads the cell at read_row/read_col.
// - result channel (res_valid/res_stall): one result per request with the
//   written or read cell, the cursor afterwards and a scroll flag.
// - config channel (cfg_valid/cfg_ready): index 0 foreground, 1 background
//   color; always ready, write only while no request is in flight.
// From request accept to the result: a put goes through the sequencer's done
// state into the output register, an in-range read first through a read state
// for the registered memory read; a put that leaves the last row first runs a
// scroll copy, one cell copied per cycle through the single read and write port
// of the screen memory. One request is worked on at a time; the next is taken
// while a finished result waits in the output register.
// Reset sets the cursor to 0, the colors to foreground 15 and background 0,
// then a clearing pass zeroes the screen memory with req_stall high.
// While res_stall is high the result holds and, once the sequencer has a
// second result ready, req_stall stays high until the first leaves.
`timescale 1ns / 1ps
`include "text_console_writer_top_defines.svh"

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 req_type,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [ROW_IN_W-1:0]  read_row,
  input  logic [COL_IN_W-1:0]  read_col,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [CELL_W-1:0]    cell_data,
  output logic [COL_OUT_W-1:0] cursor_col,
  output logic [ROW_OUT_W-1:0] cursor_row,
  output logic                 scrolled,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bgnd_color;

  tcw_req_t          req;
  tcw_result_t       seq_res;
  tcw_result_t       res;
  tcw_status_t       status;
  logic              seq_res_valid;
  logic              res_take;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color   <= 4'd15;
      bgnd_color <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FG:   fg_color   <= cfg_data;
        REG_BGND: bgnd_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req.req_type  = req_type;
  assign req.char_code = char_code;
  assign req.read_row  = read_row;
  assign req.read_col  = read_col;

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .attr      ({bgnd_color, fg_color}),
    .res       (seq_res),
    .res_valid (seq_res_valid),
    .res_take  (res_take),
    .status    (status),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register, refilled in the cycle its contents leave
  assign res_take = seq_res_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (res_take) begin
      res <= seq_res;
    end
  end

  assign cell_data  = res.cell_data;
  assign cursor_col = res.cursor_col;
  assign cursor_row = res.cursor_row;
  assign scrolled   = res.scrolled;

  `TCW_ASSERT_NEXT(a_one_request_at_a_time, req_valid && !req_stall, req_stall,
    "request taken while the previous one is still in flight")
  `TCW_ASSERT_SAME(a_no_request_while_clearing, status.clearing, req_stall,
    "request taken during the clearing pass")
  `TCW_ASSERT_SAME(a_scroll_blocks, status.scrolling, req_stall && !seq_res_valid,
    "request or result during a scroll copy")

endmodule

FILE: sv/tcw_screen_ram.sv
// screen cell memory: one write port, one read port, registered read data
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = 4000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tcw_seq.sv
// request sequencer: cursor, clearing pass, scroll copy and memory access
// depends on tcw_pkg; drives tcw_screen_ram
`timescale 1ns / 1ps

module tcw_seq
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 50,
  localparam int DEPTH  = ROWS * COLUMNS,
  localparam int AW     = $clog2(DEPTH),
  localparam int CW     = $clog2(COLUMNS),
  localparam int RW     = $clog2(ROWS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcw_req_t             req,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [CHAR_W-1:0]    attr,
  output tcw_result_t          res,
  output logic                 res_valid,
  input  logic                 res_take,
  output tcw_status_t          status,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [CELL_W-1:0]    mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [CELL_W-1:0]    mem_rdata
);

  localparam int SCROLL_LEN = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     cur_col, cur_col_next;
  logic [RW-1:0]     cur_row, cur_row_next;
  logic [CELL_W-1:0] cell_word, cell_word_next;
  logic              scrolled, scrolled_next;

  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_in_range;
  logic [CELL_W-1:0] wr_word;
  logic              wrap;

  assign cur_addr    = AW'(cur_row * COLUMNS) + AW'(cur_col);
  assign rd_addr     = AW'(req.read_row * COLUMNS) + AW'(req.read_col);
  assign rd_in_range = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLUMNS);
  assign wr_word     = {attr, req.char_code};

  assign req_stall = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

  assign res.cell_data  = cell_word;
  assign res.cursor_col = COL_OUT_W'(cur_col);
  assign res.cursor_row = ROW_OUT_W'(cur_row);
  assign res.scrolled   = scrolled;

  assign status.clearing  = (state == ST_CLEAR);
  assign status.scrolling = (state == ST_SCROLL);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    cell_word_next = cell_word;
    scrolled_next  = scrolled;
    mem_we         = 1'b0;
    mem_waddr      = cur_addr;
    mem_wdata      = wr_word;
    mem_re         = 1'b0;
    mem_raddr      = rd_addr;
    wrap           = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = '0;
        cnt_next  = cnt + AW'(1);
        if (cnt == AW'(DEPTH - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          scrolled_next = 1'b0;
          if (req.req_type == REQ_READ) begin
            if (rd_in_range) begin
              mem_re     = 1'b1;
              state_next = ST_READ;
            end else begin
              cell_word_next = '0;
              state_next     = ST_DONE;
            end
          end else begin
            if (req.char_code == NEWLINE_CODE) begin
              cell_word_next = '0;
              wrap           = 1'b1;
            end else begin
              mem_we         = 1'b1;
              cell_word_next = wr_word;
              wrap           = (cur_col == CW'(COLUMNS - 1));
              cur_col_next   = cur_col + CW'(1);
            end
            state_next = ST_DONE;
            if (wrap) begin
              cur_col_next = '0;
              if (cur_row == RW'(ROWS - 1)) begin
                // leaving the last row: copy everything up one row
                scrolled_next = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SCROLL;
              end else begin
                cur_row_next = cur_row + RW'(1);
              end
            end
          end
        end
      end
      ST_READ: begin
        cell_word_next = mem_rdata;
        state_next     = ST_DONE;
      end
      ST_SCROLL: begin
        // read runs one entry ahead of the write, one row further down
        mem_re    = (cnt != AW'(SCROLL_LEN));
        mem_raddr = cnt + AW'(COLUMNS);
        mem_we    = (cnt != '0);
        mem_waddr = cnt - AW'(1);
        mem_wdata = mem_rdata;
        cnt_next  = cnt + AW'(1);
        if (cnt == AW'(SCROLL_LEN)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cnt     <= '0;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
    cell_word <= cell_word_next;
    scrolled  <= scrolled_next;
  end

endmodule

FILE: sim/text_console_writer_checker.sv
// checker for the text console writer: watches request, result and config channels,
// keeps its own screen, cursor and colors, and compares every result in order
// depends on tcw_pkg
`timescale 1ns / 1ps

module text_console_writer_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  logic                 req_type,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [ROW_IN_W-1:0]  read_row,
  input  logic [COL_IN_W-1:0]  read_col,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  logic [CELL_W-1:0]    cell_data,
  input  logic [COL_OUT_W-1:0] cursor_col,
  input  logic [ROW_OUT_W-1:0] cursor_row,
  input  logic                 scrolled,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  output int                   fail_count,
  output int                   pending_count,
  output int                   result_count,
  output int                   scroll_count
);

  logic [CELL_W-1:0]  screen_cells [ROWS*COLUMNS];
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bgnd_color;
  tcw_result_t        awaited_results [$];

  // move to the start of the next row, shifting the screen up past the last row
  function automatic bit advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
        screen_cells[i] = screen_cells[i + COLUMNS];
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic tcw_result_t console_step(tcw_req_t r);
    tcw_result_t res;
    res = '0;
    if (r.req_type == REQ_READ) begin
      if (r.read_row < ROWS && r.read_col < COLUMNS)
        res.cell_data = screen_cells[r.read_row * COLUMNS + r.read_col];
    end else if (r.char_code == NEWLINE_CODE) begin
      res.scrolled = advance_line();
    end else begin
      res.cell_data = {bgnd_color, fg_color, r.char_code};
      if (cur_row < ROWS && cur_col < COLUMNS)
        screen_cells[cur_row * COLUMNS + cur_col] = res.cell_data;
      cur_col++;
      if (cur_col >= COLUMNS)
        res.scrolled = advance_line();
    end
    res.cursor_col = COL_OUT_W'(cur_col);
    res.cursor_row = ROW_OUT_W'(cur_row);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tcw_result_t want;
    tcw_req_t    req;
    if (rst) begin
      foreach (screen_cells[i]) screen_cells[i] = '0;
      cur_col = 0;
      cur_row = 0;
      fg_color = 4'd15;
      bgnd_color = 4'd0;
      awaited_results.delete();
      fail_count = 0;
      result_count = 0;
      scroll_count = 0;
    end else begin
      // results first: a request taken at this edge cannot be answered yet
      if (res_valid && !res_stall) begin
        result_count++;
        if (scrolled) scroll_count++;
        if (awaited_results.size() == 0) begin
          $error("result with nothing outstanding: cell_data %h", cell_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (cell_data !== want.cell_data) begin
            $error("cell_data: expected %h, actual %h", want.cell_data, cell_data);
            fail_count++;
          end
          if (cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, actual %0d", want.cursor_col, cursor_col);
            fail_count++;
          end
          if (cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, actual %0d", want.cursor_row, cursor_row);
            fail_count++;
          end
          if (scrolled !== want.scrolled) begin
            $error("scrolled: expected %0b, actual %0b", want.scrolled, scrolled);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FG) fg_color = cfg_data;
        else if (cfg_index == REG_BGND) bgnd_color = cfg_data;
      end
      if (req_valid && !req_stall) begin
        req = '{req_type, char_code, read_row, read_col};
        awaited_results.push_back(console_step(req));
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

FILE: sim/tb.sv
// testbench top for the text console writer: clock, reset, request and config
// stimulus with random idling; checking is done by text_console_writer_checker
// depends on tcw_pkg, text_console_writer_top and text_console_writer_checker
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 50;
  localparam int ITEM_TOTAL  = 1350;
  localparam int PHASES      = 5;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 2000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic                 req_type = REQ_PUT;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [ROW_IN_W-1:0]  read_row = '0;
  logic [COL_IN_W-1:0]  read_col = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [CELL_W-1:0]    cell_data;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic                 scrolled;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FG;
  logic [COLOR_W-1:0]   cfg_data = '0;

  int fail_count;
  int pending_count;
  int result_count;
  int scroll_count;
  int items_sent = 0;
  int directed_count = 0;
  int color_settings = 1;
  int cycles = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  always #10 clk = ~clk;

  text_console_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_dut (
    .clk, .rst,
    .req_valid, .req_stall, .req_type, .char_code, .read_row, .read_col,
    .res_valid, .res_stall, .cell_data, .cursor_col, .cursor_row, .scrolled,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  text_console_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_checker (
    .clk, .rst,
    .req_valid, .req_stall, .req_type, .char_code, .read_row, .read_col,
    .res_valid, .res_stall, .cell_data, .cursor_col, .cursor_row, .scrolled,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_count, .result_count, .scroll_count
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_count);
      $display("FAILURE");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (rst || no_idle) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      res_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // unused fields of a request still get random values
  function automatic tcw_req_t make_put(logic [CHAR_W-1:0] code);
    tcw_req_t r;
    r.req_type  = REQ_PUT;
    r.char_code = code;
    r.read_row  = ROW_IN_W'($urandom_range(0, 63));
    r.read_col  = COL_IN_W'($urandom_range(0, 127));
    return r;
  endfunction

  function automatic tcw_req_t make_read(int row, int col);
    tcw_req_t r;
    r.req_type  = REQ_READ;
    r.char_code = CHAR_W'($urandom_range(0, 255));
    r.read_row  = ROW_IN_W'(row);
    r.read_col  = COL_IN_W'(col);
    return r;
  endfunction

  task automatic send(tcw_req_t r);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_type  <= r.req_type;
    char_code <= r.char_code;
    read_row  <= r.read_row;
    read_col  <= r.read_col;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one burst: a line of text, a run of reads, or a fully random request
  task automatic random_burst();
    int kind;
    int len;
    int sel;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(78, 82) : $urandom_range(0, 12);
      repeat (len) send(make_put(CHAR_W'($urandom_range(0, 255))));
      if ($urandom_range(0, 99) < 85) send(make_put(NEWLINE_CODE));
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 6)) begin
        sel = $urandom_range(0, 99);
        if (sel < 15)
          send(make_read($urandom_range(0, 63), $urandom_range(0, 127)));
        else if (sel < 55)
          send(make_read($urandom_range(0, ROWS - 1), $urandom_range(0, 15)));
        else
          send(make_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1)));
      end
    end else begin
      send($urandom_range(0, 1) ? make_read($urandom_range(0, 63), $urandom_range(0, 127))
                                : make_put(CHAR_W'($urandom_range(0, 255))));
    end
  endtask

  initial begin : stimulus
    logic [COLOR_W-1:0] fg_set [PHASES];
    logic [COLOR_W-1:0] bg_set [PHASES];
    fg_set = '{4'd0, 4'd15, 4'd0, 4'd15, COLOR_W'($urandom_range(0, 15))};
    bg_set = '{4'd0, 4'd15, 4'd15, 4'd0, COLOR_W'($urandom_range(0, 15))};

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: cleared screen, extreme codes, newlines, reads in and out of range
    send(make_read(0, 0));
    send(make_put(8'h00));
    send(make_put(8'hFF));
    send(make_put(8'h41));
    send(make_put(8'h0B));
    send(make_put(8'h09));
    send(make_put(NEWLINE_CODE));
    send(make_put(NEWLINE_CODE));
    send(make_read(0, 0));
    send(make_read(0, 1));
    send(make_read(0, 4));
    send(make_read(0, 5));
    send(make_read(ROWS - 1, COLUMNS - 1));
    send(make_read(ROWS, 0));
    send(make_read(0, COLUMNS));
    send(make_read(63, 127));
    send(make_read(ROWS - 1, COLUMNS));
    send(make_put(8'h80));
    send(make_put(8'h7F));
    send(make_read(2, 0));
    send(make_read(2, 1));
    send(make_put(NEWLINE_CODE));
    directed_count = items_sent;

    for (int p = 0; p < PHASES; p++) begin
      // sender holds off until every outstanding request is answered
      wait_idle();
      write_reg(REG_FG, fg_set[p]);
      write_reg(REG_BGND, bg_set[p]);
      color_settings++;
      while (items_sent < directed_count + (p + 1) * (ITEM_TOTAL / PHASES)) begin
        no_idle = (p == 2) || (items_sent >= ITEM_TOTAL - QUIET_TAIL);
        random_burst();
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("sent %0d requests (%0d directed) under %0d color settings",
             items_sent, directed_count, color_settings);
    $display("checked %0d results, %0d of them scrolled the screen",
             result_count, scroll_count);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
